// File: design/bfp_pkg.sv
package bfp_pkg;

  localparam logic [7:0]  SYNC_FIRST         = 8'hB5;
  localparam logic [7:0]  SYNC_SECOND        = 8'h62;
  localparam logic [15:0] PAYLOAD_LIMIT_INIT = 16'd256;
  localparam int          QUEUE_DEPTH        = 2;

  typedef enum logic [3:0] {
    PH_SYNC1  = 4'd0,
    PH_SYNC2  = 4'd1,
    PH_CLASS  = 4'd2,
    PH_ID     = 4'd3,
    PH_LEN_LO = 4'd4,
    PH_LEN_HI = 4'd5,
    PH_DATA   = 4'd6,
    PH_CK_A   = 4'd7,
    PH_CK_B   = 4'd8
  } phase_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_VERDICT = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic [15:0] index;
    logic [7:0]  msg_class;
    logic [7:0]  msg_id;
    logic [15:0] length;
    logic        first_bad;
    logic        second_bad;
    logic        too_long;
    logic        good;
  } result_t;

endpackage

// File: design/bfp_front.sv
module bfp_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  logic [7:0]         rx_byte,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  output logic               push,
  output bfp_pkg::result_t   item
);

  bfp_pkg::phase_t phase, phase_next;
  logic [15:0] payload_limit;
  logic [7:0]  class_reg, class_reg_next;
  logic [7:0]  id_reg, id_reg_next;
  logic [15:0] length_reg, length_reg_next;
  logic [15:0] received_count, received_count_next;
  logic [7:0]  sum_a, sum_a_next;
  logic [7:0]  sum_b, sum_b_next;
  logic        length_ok, length_ok_next;
  logic        first_mismatch, first_mismatch_next;
  logic [7:0]  add_a;
  logic [7:0]  add_b;
  logic [15:0] full_length;
  logic [15:0] count_inc;

  assign add_a       = sum_a + rx_byte;
  assign add_b       = sum_b + add_a;
  assign full_length = {rx_byte, length_reg[7:0]};
  assign count_inc   = received_count + 16'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= bfp_pkg::PH_SYNC1;
      payload_limit  <= bfp_pkg::PAYLOAD_LIMIT_INIT;
      class_reg      <= '0;
      id_reg         <= '0;
      length_reg     <= '0;
      received_count <= '0;
      sum_a          <= '0;
      sum_b          <= '0;
      length_ok      <= 1'b0;
      first_mismatch <= 1'b0;
    end else begin
      if (cfg_we) begin
        payload_limit <= cfg_wdata;
      end
      if (take) begin
        phase          <= phase_next;
        class_reg      <= class_reg_next;
        id_reg         <= id_reg_next;
        length_reg     <= length_reg_next;
        received_count <= received_count_next;
        sum_a          <= sum_a_next;
        sum_b          <= sum_b_next;
        length_ok      <= length_ok_next;
        first_mismatch <= first_mismatch_next;
      end
    end
  end

  always_comb begin
    phase_next          = phase;
    class_reg_next      = class_reg;
    id_reg_next         = id_reg;
    length_reg_next     = length_reg;
    received_count_next = received_count;
    sum_a_next          = sum_a;
    sum_b_next          = sum_b;
    length_ok_next      = length_ok;
    first_mismatch_next = first_mismatch;
    push                = 1'b0;
    item                = '0;
    item.msg_class      = class_reg;
    item.msg_id         = id_reg;
    item.length         = length_reg;
    unique case (phase)
      bfp_pkg::PH_SYNC2: begin
        if (rx_byte == bfp_pkg::SYNC_SECOND) begin
          sum_a_next = '0;
          sum_b_next = '0;
          phase_next = bfp_pkg::PH_CLASS;
        end else begin
          phase_next = bfp_pkg::PH_SYNC1;
        end
      end
      bfp_pkg::PH_CLASS: begin
        class_reg_next = rx_byte;
        sum_a_next     = add_a;
        sum_b_next     = add_b;
        phase_next     = bfp_pkg::PH_ID;
      end
      bfp_pkg::PH_ID: begin
        id_reg_next = rx_byte;
        sum_a_next  = add_a;
        sum_b_next  = add_b;
        phase_next  = bfp_pkg::PH_LEN_LO;
      end
      bfp_pkg::PH_LEN_LO: begin
        length_reg_next = {8'd0, rx_byte};
        sum_a_next      = add_a;
        sum_b_next      = add_b;
        phase_next      = bfp_pkg::PH_LEN_HI;
      end
      bfp_pkg::PH_LEN_HI: begin
        length_reg_next     = full_length;
        sum_a_next          = add_a;
        sum_b_next          = add_b;
        received_count_next = '0;
        first_mismatch_next = 1'b0;
        length_ok_next      = full_length < payload_limit;
        phase_next          = (full_length != 16'd0) ? bfp_pkg::PH_DATA : bfp_pkg::PH_CK_A;
      end
      bfp_pkg::PH_DATA: begin
        push                = length_ok;
        item.kind           = bfp_pkg::KIND_PAYLOAD;
        item.data           = rx_byte;
        item.index          = received_count;
        sum_a_next          = add_a;
        sum_b_next          = add_b;
        received_count_next = count_inc;
        if (count_inc == length_reg) begin
          phase_next = bfp_pkg::PH_CK_A;
        end
      end
      bfp_pkg::PH_CK_A: begin
        first_mismatch_next = rx_byte != sum_a;
        phase_next          = bfp_pkg::PH_CK_B;
      end
      bfp_pkg::PH_CK_B: begin
        push            = 1'b1;
        item.kind       = bfp_pkg::KIND_VERDICT;
        item.first_bad  = first_mismatch;
        item.second_bad = rx_byte != sum_b;
        item.too_long   = !length_ok;
        item.good       = !first_mismatch && (rx_byte == sum_b) && length_ok;
        phase_next      = bfp_pkg::PH_SYNC1;
      end
      default: begin
        phase_next = (rx_byte == bfp_pkg::SYNC_FIRST) ? bfp_pkg::PH_SYNC2 : bfp_pkg::PH_SYNC1;
      end
    endcase
    push = push && take;
  end

endmodule

// File: design/bfp_queue.sv
module bfp_queue #(
  parameter int Depth = bfp_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  bfp_pkg::result_t push_item,
  input  logic             pop,
  output logic             full,
  output logic             not_empty,
  output bfp_pkg::result_t head
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  bfp_pkg::result_t slots [Depth];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;
  logic             do_pop;

  assign full      = count == CntW'(Depth);
  assign not_empty = count != '0;
  assign head      = slots[rd_ptr];
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: design/bfp_back.sv
module bfp_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_not_empty,
  input  bfp_pkg::result_t q_head,
  output logic             q_pop,
  input  logic             out_stall,
  output logic             out_valid,
  output bfp_pkg::result_t out_item
);

  assign q_pop = q_not_empty && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= q_not_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_item <= q_head;
    end
  end

endmodule

// File: design/binary_frame_parser_fletcher8.sv
// Binary frame parser with 8-bit Fletcher check.
// Input channel: one received byte per transfer on rx_byte (rx_valid/rx_stall).
// The parser hunts for sync bytes B5 62, takes class, id and a little-endian
// length, then forwards each payload byte as a result (result_kind 0) when the
// length is below payload_limit. The second checksum byte yields a frame-end
// result (result_kind 1) carrying header values and the error flags.
// Header, sync and first checksum bytes yield no result.
// Config: cfg_we writes cfg_wdata into payload_limit; sampled at the high
// length byte. Write only while the block is idle.
// Throughput: one byte per cycle while rx_stall is low; the parser state is registered on each accepted byte.
// Path: a result is written into the queue when its byte is transferred, then
// moves into the output register when the output is not stalled.
// Reset: parser waits for the first sync byte, payload_limit = 256, queue and
// output register empty.
// Output stall: the output register holds; the queue between parser and
// output absorbs up to QueueDepth results, then rx_stall rises until the
// output side drains.
module binary_frame_parser_fletcher8 #(
  parameter int QueueDepth = bfp_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        rx_valid,
  output logic        rx_stall,
  input  logic [7:0]  rx_byte,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  output logic        result_valid,
  input  logic        result_stall,
  output logic        result_kind,
  output logic [7:0]  payload_byte,
  output logic [15:0] payload_index,
  output logic [7:0]  message_class,
  output logic [7:0]  message_id,
  output logic [15:0] payload_length,
  output logic        first_sum_bad,
  output logic        second_sum_bad,
  output logic        too_long,
  output logic        frame_good
);

  logic             take;
  logic             push;
  logic             q_full;
  logic             q_not_empty;
  logic             q_pop;
  bfp_pkg::result_t push_item;
  bfp_pkg::result_t q_head;
  bfp_pkg::result_t out_item;

  assign rx_stall = q_full;
  assign take     = rx_valid && !q_full;

  bfp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .rx_byte   (rx_byte),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .push      (push),
    .item      (push_item)
  );

  bfp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  bfp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_stall   (result_stall),
    .out_valid   (result_valid),
    .out_item    (out_item)
  );

  assign result_kind    = out_item.kind;
  assign payload_byte   = out_item.data;
  assign payload_index  = out_item.index;
  assign message_class  = out_item.msg_class;
  assign message_id     = out_item.msg_id;
  assign payload_length = out_item.length;
  assign first_sum_bad  = out_item.first_bad;
  assign second_sum_bad = out_item.second_bad;
  assign too_long       = out_item.too_long;
  assign frame_good     = out_item.good;

endmodule

// File: design/bfp_checker.sv
module bfp_checker (
  input logic        clk,
  input logic        rst,
  input logic        result_valid,
  input logic        result_stall,
  input logic        result_kind,
  input logic [15:0] payload_index,
  input logic [15:0] payload_length,
  input logic        first_sum_bad,
  input logic        second_sum_bad,
  input logic        too_long,
  input logic        frame_good
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("stalled result dropped");

  a_good: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_kind |->
      frame_good == !(first_sum_bad || second_sum_bad || too_long))
    else $error("frame_good disagrees with flags");

  a_payload_flags: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_kind |->
      !first_sum_bad && !second_sum_bad && !too_long && !frame_good)
    else $error("flags set on payload result");

  a_index: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_kind |-> payload_index < payload_length)
    else $error("payload index beyond length");

endmodule

bind binary_frame_parser_fletcher8 bfp_checker u_bfp_checker (
  .clk            (clk),
  .rst            (rst),
  .result_valid   (result_valid),
  .result_stall   (result_stall),
  .result_kind    (result_kind),
  .payload_index  (payload_index),
  .payload_length (payload_length),
  .first_sum_bad  (first_sum_bad),
  .second_sum_bad (second_sum_bad),
  .too_long       (too_long),
  .frame_good     (frame_good)
);

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int CK_OK       = 0;
  localparam int CK_BAD_A    = 1;
  localparam int CK_BAD_B    = 2;
  localparam int CK_BAD_BOTH = 3;
  localparam int STALL_LIMIT = 2000;
  localparam int SEG_BYTES   = 100;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        rx_valid = 1'b0;
  logic        rx_stall;
  logic [7:0]  rx_byte = 8'h00;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = 16'h0000;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic        result_kind;
  logic [7:0]  payload_byte;
  logic [15:0] payload_index;
  logic [7:0]  message_class;
  logic [7:0]  message_id;
  logic [15:0] payload_length;
  logic        first_sum_bad;
  logic        second_sum_bad;
  logic        too_long;
  logic        frame_good;

  binary_frame_parser_fletcher8 DUT (
    .clk           (clk),
    .rst           (rst),
    .rx_valid      (rx_valid),
    .rx_stall      (rx_stall),
    .rx_byte       (rx_byte),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result_kind   (result_kind),
    .payload_byte  (payload_byte),
    .payload_index (payload_index),
    .message_class (message_class),
    .message_id    (message_id),
    .payload_length(payload_length),
    .first_sum_bad (first_sum_bad),
    .second_sum_bad(second_sum_bad),
    .too_long      (too_long),
    .frame_good    (frame_good)
  );

  always #5 clk = ~clk;

  logic [7:0]        rx_pending[$];
  bfp_pkg::result_t  expected_results[$];
  bfp_pkg::result_t  exp_r;
  int                bytes_queued = 0;
  int                bytes_sent = 0;
  int                fail_count = 0;
  int                src_idle_pct = 0;
  int                rcv_idle_pct = 0;
  int                quiet_cycles = 0;

  // parser model state
  logic [15:0]       limit_model = bfp_pkg::PAYLOAD_LIMIT_INIT;
  bfp_pkg::phase_t   ph = bfp_pkg::PH_SYNC1;
  logic [7:0]        frm_class = '0;
  logic [7:0]        frm_id = '0;
  logic [15:0]       frm_len = '0;
  logic [15:0]       byte_count = '0;
  logic [7:0]        fl_a = '0;
  logic [7:0]        fl_b = '0;
  logic              frm_len_ok = 1'b0;
  logic              ck_a_bad = 1'b0;

  task automatic parse_byte(input logic [7:0] b);
    bfp_pkg::result_t r;
    logic             ck_b_bad;
    r = '0;
    if (ph >= bfp_pkg::PH_CLASS && ph <= bfp_pkg::PH_DATA) begin
      fl_a += b;
      fl_b += fl_a;
    end
    case (ph)
      bfp_pkg::PH_SYNC2: begin
        if (b == bfp_pkg::SYNC_SECOND) begin
          fl_a = '0;
          fl_b = '0;
          ph = bfp_pkg::PH_CLASS;
        end else begin
          ph = bfp_pkg::PH_SYNC1;
        end
      end
      bfp_pkg::PH_CLASS: begin
        frm_class = b;
        ph = bfp_pkg::PH_ID;
      end
      bfp_pkg::PH_ID: begin
        frm_id = b;
        ph = bfp_pkg::PH_LEN_LO;
      end
      bfp_pkg::PH_LEN_LO: begin
        frm_len = {8'h00, b};
        ph = bfp_pkg::PH_LEN_HI;
      end
      bfp_pkg::PH_LEN_HI: begin
        frm_len[15:8] = b;
        byte_count = '0;
        ck_a_bad = 1'b0;
        frm_len_ok = frm_len < limit_model;
        ph = (frm_len != 16'd0) ? bfp_pkg::PH_DATA : bfp_pkg::PH_CK_A;
      end
      bfp_pkg::PH_DATA: begin
        if (frm_len_ok) begin
          r.kind = bfp_pkg::KIND_PAYLOAD;
          r.data = b;
          r.index = byte_count;
          r.msg_class = frm_class;
          r.msg_id = frm_id;
          r.length = frm_len;
          expected_results.push_back(r);
        end
        byte_count++;
        if (byte_count == frm_len) ph = bfp_pkg::PH_CK_A;
      end
      bfp_pkg::PH_CK_A: begin
        ck_a_bad = (b != fl_a);
        ph = bfp_pkg::PH_CK_B;
      end
      bfp_pkg::PH_CK_B: begin
        ck_b_bad = (b != fl_b);
        r.kind = bfp_pkg::KIND_VERDICT;
        r.msg_class = frm_class;
        r.msg_id = frm_id;
        r.length = frm_len;
        r.first_bad = ck_a_bad;
        r.second_bad = ck_b_bad;
        r.too_long = !frm_len_ok;
        r.good = !ck_a_bad && !ck_b_bad && frm_len_ok;
        expected_results.push_back(r);
        ph = bfp_pkg::PH_SYNC1;
      end
      default: ph = (b == bfp_pkg::SYNC_FIRST) ? bfp_pkg::PH_SYNC2 : bfp_pkg::PH_SYNC1;
    endcase
  endtask

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  task automatic push_byte(input logic [7:0] b);
    rx_pending.push_back(b);
    bytes_queued++;
  endtask

  task automatic queue_frame(input logic [7:0] cls, input logic [7:0] id,
                             input logic [15:0] len, input int ck_mode,
                             input bit extremes);
    logic [7:0] hdr[4];
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] pb;
    a = '0;
    b = '0;
    hdr[0] = cls;
    hdr[1] = id;
    hdr[2] = len[7:0];
    hdr[3] = len[15:8];
    push_byte(bfp_pkg::SYNC_FIRST);
    push_byte(bfp_pkg::SYNC_SECOND);
    foreach (hdr[i]) begin
      push_byte(hdr[i]);
      a += hdr[i];
      b += a;
    end
    for (int i = 0; i < len; i++) begin
      pb = extremes ? (i[0] ? 8'h00 : 8'hFF) : 8'($urandom_range(255));
      push_byte(pb);
      a += pb;
      b += a;
    end
    if (ck_mode == CK_BAD_A || ck_mode == CK_BAD_BOTH) a ^= 8'($urandom_range(1, 255));
    if (ck_mode == CK_BAD_B || ck_mode == CK_BAD_BOTH) b ^= 8'($urandom_range(1, 255));
    push_byte(a);
    push_byte(b);
  endtask

  // mostly good frames; some noise, broken sync and bad checksums
  task automatic queue_random_unit();
    int          pick;
    int          n;
    int          ck_mode;
    logic [7:0]  nb;
    logic [15:0] len;
    pick = $urandom_range(99);
    if (pick < 8) begin
      n = $urandom_range(1, 4);
      repeat (n) begin
        nb = 8'($urandom_range(255));
        if (nb == bfp_pkg::SYNC_FIRST) nb = 8'h00;
        push_byte(nb);
      end
    end else if (pick < 13) begin
      push_byte(bfp_pkg::SYNC_FIRST);
      nb = 8'($urandom_range(255));
      if (nb == bfp_pkg::SYNC_SECOND) nb = bfp_pkg::SYNC_FIRST;
      push_byte(nb);
    end else begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        len = 16'($urandom_range(0, 6));
      end else if (pick < 80 && limit_model <= 16'd40) begin
        len = (limit_model == 16'd0) ? 16'($urandom_range(0, 1))
                                     : limit_model - 16'd1 + 16'($urandom_range(0, 2));
      end else begin
        len = 16'($urandom_range(7, 40));
      end
      ck_mode = ($urandom_range(99) < 80) ? CK_OK : $urandom_range(CK_BAD_A, CK_BAD_BOTH);
      queue_frame(8'($urandom_range(255)), 8'($urandom_range(255)), len, ck_mode, 1'b0);
    end
  endtask

  task automatic wait_drained();
    while (bytes_sent != bytes_queued || expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_limit(input logic [15:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    limit_model = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // byte driver
  always @(posedge clk) begin
    if (rst) begin
      rx_valid <= 1'b0;
    end else begin
      if (rx_valid && !rx_stall) begin
        parse_byte(rx_byte);
        bytes_sent++;
      end
      if (!rx_valid || !rx_stall) begin
        if (rx_pending.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          rx_valid <= 1'b1;
          rx_byte <= rx_pending.pop_front();
        end else begin
          rx_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with nothing expected");
          fail_count++;
        end else begin
          exp_r = expected_results.pop_front();
          check_field("result_kind", exp_r.kind, result_kind);
          check_field("payload_byte", exp_r.data, payload_byte);
          check_field("payload_index", exp_r.index, payload_index);
          check_field("message_class", exp_r.msg_class, message_class);
          check_field("message_id", exp_r.msg_id, message_id);
          check_field("payload_length", exp_r.length, payload_length);
          check_field("first_sum_bad", exp_r.first_bad, first_sum_bad);
          check_field("second_sum_bad", exp_r.second_bad, second_sum_bad);
          check_field("too_long", exp_r.too_long, too_long);
          check_field("frame_good", exp_r.good, frame_good);
        end
      end
      result_stall <= ($urandom_range(99) < rcv_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || cfg_we || (rx_valid && !rx_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [15:0] seg_limit[6];
    int          start;
    seg_limit[0] = bfp_pkg::PAYLOAD_LIMIT_INIT;
    seg_limit[1] = 16'd0;
    seg_limit[2] = 16'hFFFF;
    seg_limit[3] = 16'd3;
    seg_limit[4] = 16'($urandom_range(1, 40));
    seg_limit[5] = 16'd1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    for (int seg = 0; seg < 6; seg++) begin
      if (seg > 0) begin
        wait_drained();
        repeat (6) @(posedge clk);
      end
      write_limit(seg_limit[seg]);
      case (seg / 2)
        0: begin
          src_idle_pct = 7;
          rcv_idle_pct = 67;
        end
        1: begin
          src_idle_pct = 67;
          rcv_idle_pct = 7;
        end
        default: begin
          src_idle_pct = 0;
          rcv_idle_pct = 0;
        end
      endcase
      if (seg == 0) begin
        queue_frame(8'hFF, 8'h00, 16'd0, CK_OK, 1'b0);
        // second sync byte that is itself a first sync byte
        push_byte(bfp_pkg::SYNC_FIRST);
        push_byte(bfp_pkg::SYNC_FIRST);
        push_byte(bfp_pkg::SYNC_SECOND);
        queue_frame(8'h00, 8'hFF, 16'd2, CK_BAD_A, 1'b1);
        queue_frame(8'h55, 8'hAA, 16'd1, CK_BAD_B, 1'b1);
        queue_frame(8'h01, 8'h80, 16'd255, CK_OK, 1'b0);
        queue_frame(8'h02, 8'h7F, 16'd256, CK_OK, 1'b0);
      end
      if (seg == 2) queue_frame(8'h0A, 8'h0B, 16'd300, CK_OK, 1'b0);
      start = bytes_queued;
      while (bytes_queued - start < SEG_BYTES) queue_random_unit();
    end
    wait_drained();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/bfp_pkg.sv
design/bfp_front.sv
design/bfp_queue.sv
design/bfp_back.sv
design/binary_frame_parser_fletcher8.sv
design/bfp_checker.sv
sim/testbench.sv
